FILE: sv/bcw_pkg.sv
`default_nettype none
package bcw_pkg;

   localparam int OFFSET_FRAC_BITS = 17;
   localparam int WEIGHT_FRAC_BITS = 24;
   localparam int ACC_FRAC_BITS    = 28;
   localparam int OFFSET_W         = 18;
   localparam int WEIGHT_W         = 25;
   localparam int ACC_W            = 46;
   localparam int COEF_W           = 16;
   localparam int QUOT_W           = 30;
   localparam int RECIP_BITS       = 36;
   localparam int MUL_W            = 6;
   localparam int SHIFT_W          = 4;
   localparam int HORNER_STEPS     = 6;
   localparam int LATENCY          = HORNER_STEPS + 4;

   typedef enum logic [1:0] {
      KIND_POLY,
      KIND_ONE,
      KIND_ERR
   } kind_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [6:0] coef_set_type;

   typedef struct packed {
      logic                        valid;
      kind_type                    kind;
      logic [2:0]                  order;
      logic [2:0]                  index;
      logic signed [OFFSET_W-1:0]  x;
   } ctrl_type;

   function automatic coef_set_type mk(input int c0, input int c1, input int c2,
                                       input int c3, input int c4, input int c5,
                                       input int c6);
      coef_set_type r;
      r[0] = COEF_W'(c0);
      r[1] = COEF_W'(c1);
      r[2] = COEF_W'(c2);
      r[3] = COEF_W'(c3);
      r[4] = COEF_W'(c4);
      r[5] = COEF_W'(c5);
      r[6] = COEF_W'(c6);
      return r;
   endfunction

   function automatic coef_set_type coefs(input logic [2:0] order, input logic [2:0] index);
      coef_set_type r;
      r = mk(0, 0, 0, 0, 0, 0, 0);
      case ({order, index})
         6'o20: r = mk(1, -2, 0, 0, 0, 0, 0);
         6'o21: r = mk(1, 2, 0, 0, 0, 0, 0);
         6'o30: r = mk(1, -4, 4, 0, 0, 0, 0);
         6'o31: r = mk(6, 0, -8, 0, 0, 0, 0);
         6'o32: r = mk(1, 4, 4, 0, 0, 0, 0);
         6'o40: r = mk(1, -6, 12, -8, 0, 0, 0);
         6'o41: r = mk(23, -30, -12, 24, 0, 0, 0);
         6'o42: r = mk(23, 30, -12, -24, 0, 0, 0);
         6'o43: r = mk(1, 6, 12, 8, 0, 0, 0);
         6'o50: r = mk(1, -8, 24, -32, 16, 0, 0);
         6'o51: r = mk(19, -44, 24, 16, -16, 0, 0);
         6'o52: r = mk(115, 0, -120, 0, 48, 0, 0);
         6'o53: r = mk(19, 44, 24, -16, -16, 0, 0);
         6'o54: r = mk(1, 8, 24, 32, 16, 0, 0);
         6'o60: r = mk(1, -10, 40, -80, 80, -32, 0);
         6'o61: r = mk(237, -750, 840, -240, -240, 160, 0);
         6'o62: r = mk(841, -770, -440, 560, 80, -160, 0);
         6'o63: r = mk(841, 770, -440, -560, 80, 160, 0);
         6'o64: r = mk(237, 750, 840, 240, -240, -160, 0);
         6'o65: r = mk(1, 10, 40, 80, 80, 32, 0);
         6'o70: r = mk(1, -12, 60, -160, 240, -192, 64);
         6'o71: r = mk(361, -1416, 2220, -1600, 240, 384, -192);
         6'o72: r = mk(10543, -17340, 4740, 6880, -4080, -960, 960);
         6'o73: r = mk(5887, 0, -4620, 0, 1680, 0, -320);
         6'o74: r = mk(10543, 17340, 4740, -6880, -4080, 960, 960);
         6'o75: r = mk(361, 1416, 2220, 1600, 240, -384, -192);
         6'o76: r = mk(1, 12, 60, 160, 240, 192, 64);
         default: r = mk(0, 0, 0, 0, 0, 0, 0);
      endcase
      return r;
   endfunction

   // divisor * 2^(ACC_FRAC_BITS - WEIGHT_FRAC_BITS) = 2^shift * mul
   function automatic logic [SHIFT_W-1:0] den_shift(input logic [2:0] order,
                                                    input logic [2:0] index);
      logic [SHIFT_W-1:0] s;
      case (order)
         3'd2: s = 4'd5;
         3'd3: s = 4'd7;
         3'd4: s = 4'd8;
         3'd5: s = (index == 3'd0 || index == 3'd4) ? 4'd11 :
                   (index == 3'd2) ? 4'd10 : 4'd9;
         3'd6: s = (index == 3'd2 || index == 3'd3) ? 4'd11 : 4'd12;
         3'd7: s = (index == 3'd3) ? 4'd12 :
                   (index == 3'd1 || index == 3'd5) ? 4'd13 : 4'd14;
         default: s = 4'd5;
      endcase
      return s;
   endfunction

   function automatic logic [MUL_W-1:0] den_mul(input logic [2:0] order);
      logic [MUL_W-1:0] m;
      case (order)
         3'd4, 3'd5: m = 6'd3;
         3'd6:       m = 6'd15;
         3'd7:       m = 6'd45;
         default:    m = 6'd1;
      endcase
      return m;
   endfunction

   function automatic logic [RECIP_BITS-1:0] den_recip(input logic [2:0] order);
      logic [RECIP_BITS-1:0] r;
      case (order)
         3'd4, 3'd5: r = RECIP_BITS'((64'd1 << RECIP_BITS) / 64'd3);
         3'd6:       r = RECIP_BITS'((64'd1 << RECIP_BITS) / 64'd15);
         3'd7:       r = RECIP_BITS'((64'd1 << RECIP_BITS) / 64'd45);
         default:    r = {RECIP_BITS{1'b1}};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/bspline_charge_weight_unit.sv
// A start runs through the input register, Horner and divide stages to rsp_valid.
// Throughput: one word per cycle; busy stays low, so start may be held every cycle.
// Six Horner stages, one multiply each, then three stages of divide by constant.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset (synchronous, active high) clears the pipeline valid bits and sets order 7.
`default_nettype none
module bspline_charge_weight_unit (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   output logic                                    busy,
   input  wire  [2:0]                              req_point_index,
   input  wire  logic signed [bcw_pkg::OFFSET_W-1:0] req_offset,
   input  wire                                     csr_we,
   input  wire  [2:0]                              csr_wdata,
   output logic                                    rsp_valid,
   output logic [bcw_pkg::WEIGHT_W-1:0]            rsp_weight,
   output logic                                    rsp_index_error
);
   import bcw_pkg::*;

   localparam logic signed [OFFSET_W-1:0] LIM = OFFSET_W'(1 << (OFFSET_FRAC_BITS - 1));
   localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
   localparam int NUM_W = ACC_W;
   localparam int QP_W  = QUOT_W + RECIP_BITS;

   logic [2:0]                 order_ff;
   ctrl_type                   c0_in;
   ctrl_type                   c0_ff;
   logic signed [ACC_W-1:0]    acc0_ff;
   coef_set_type               cs0;
   ctrl_type                   hc   [HORNER_STEPS+1];
   logic signed [ACC_W-1:0]    hacc [HORNER_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 3'd7;
      end else if (csr_we) begin
         order_ff <= csr_wdata;
      end
   end

   always_comb begin
      c0_in.valid = start;
      c0_in.order = order_ff;
      c0_in.index = req_point_index;
      if (order_ff == 3'd1) begin
         c0_in.kind = KIND_ONE;
      end else if (order_ff == 3'd0 || req_point_index >= order_ff) begin
         c0_in.kind = KIND_ERR;
      end else begin
         c0_in.kind = KIND_POLY;
      end
      if (req_offset > LIM) begin
         c0_in.x = LIM;
      end else if (req_offset < -LIM) begin
         c0_in.x = -LIM;
      end else begin
         c0_in.x = req_offset;
      end
      cs0 = coefs(order_ff, req_point_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid <= 1'b0;
      end else begin
         c0_ff.valid <= c0_in.valid;
      end
      c0_ff.kind  <= c0_in.kind;
      c0_ff.order <= c0_in.order;
      c0_ff.index <= c0_in.index;
      c0_ff.x     <= c0_in.x;
      acc0_ff     <= ACC_W'(cs0[6]) <<< ACC_FRAC_BITS;
   end

   assign hc[0]   = c0_ff;
   assign hacc[0] = acc0_ff;

   for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
      bcw_horner_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .step     (3'(HORNER_STEPS - 1 - g)),
         .ctrl_in  (hc[g]),
         .acc_in   (hacc[g]),
         .ctrl_out (hc[g+1]),
         .acc_out  (hacc[g+1])
      );
   end

   // round and divide by 2^shift * mul
   ctrl_type               ch;
   logic [SHIFT_W-1:0]     sh;
   logic [MUL_W-1:0]       m1;
   logic [NUM_W-1:0]       num;
   logic [NUM_W-1:0]       tfull;
   logic                   d1_zero_in;
   logic [QUOT_W-1:0]      d1_t_in;
   logic                   d1_valid_ff, d2_valid_ff, d3_valid_ff;
   kind_type               d1_kind_ff, d2_kind_ff;
   logic                   d1_zero_ff, d2_zero_ff;
   logic [QUOT_W-1:0]      d1_t_ff, d2_t_ff;
   logic [2:0]             d1_order_ff, d2_order_ff;
   logic [QP_W-1:0]        qprod;
   logic [QUOT_W-1:0]      d2_q_in, d2_q_ff;
   logic [QUOT_W-1:0]      rem;
   logic [MUL_W-1:0]       m2;
   logic [QUOT_W-1:0]      q_fix;
   logic [WEIGHT_W-1:0]    w_in;
   logic [WEIGHT_W-1:0]    w_ff;
   logic                   err_ff;

   always_comb begin
      ch         = hc[HORNER_STEPS];
      sh         = den_shift(ch.order, ch.index);
      m1         = den_mul(ch.order);
      d1_zero_in = (hacc[HORNER_STEPS] <= 0);
      num        = NUM_W'(hacc[HORNER_STEPS]) + (NUM_W'(m1) << (sh - 4'd1));
      tfull      = num >> sh;
      if (tfull > NUM_W'({QUOT_W{1'b1}})) begin
         d1_t_in = {QUOT_W{1'b1}};
      end else begin
         d1_t_in = tfull[QUOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
      end else begin
         d1_valid_ff <= ch.valid;
         d2_valid_ff <= d1_valid_ff;
         d3_valid_ff <= d2_valid_ff;
      end
      d1_kind_ff  <= ch.kind;
      d1_zero_ff  <= d1_zero_in;
      d1_t_ff     <= d1_t_in;
      d1_order_ff <= ch.order;
      d2_kind_ff  <= d1_kind_ff;
      d2_zero_ff  <= d1_zero_ff;
      d2_t_ff     <= d1_t_ff;
      d2_order_ff <= d1_order_ff;
      d2_q_ff     <= d2_q_in;
      w_ff        <= w_in;
      err_ff      <= (d2_kind_ff == KIND_ERR);
   end

   always_comb begin
      qprod   = QP_W'(d1_t_ff) * QP_W'(den_recip(d1_order_ff));
      d2_q_in = QUOT_W'(qprod >> RECIP_BITS);
   end

   always_comb begin
      m2    = den_mul(d2_order_ff);
      rem   = d2_t_ff - QUOT_W'(d2_q_ff * QUOT_W'(m2));
      q_fix = (rem >= QUOT_W'(m2)) ? d2_q_ff + QUOT_W'(1) : d2_q_ff;
      case (d2_kind_ff)
         KIND_ONE: w_in = ONE;
         KIND_ERR: w_in = '0;
         KIND_POLY: begin
            if (d2_zero_ff) begin
               w_in = '0;
            end else if (q_fix > QUOT_W'(ONE)) begin
               w_in = ONE;
            end else begin
               w_in = WEIGHT_W'(q_fix);
            end
         end
         default: w_in = '0;
      endcase
   end

   assign busy            = 1'b0;
   assign rsp_valid       = d3_valid_ff;
   assign rsp_weight      = w_ff;
   assign rsp_index_error = err_ff;
endmodule
`default_nettype wire

FILE: sv/bcw_horner_stage.sv
`default_nettype none
module bcw_horner_stage (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire  [2:0]                                step,
   input  bcw_pkg::ctrl_type                         ctrl_in,
   input  wire  logic signed [bcw_pkg::ACC_W-1:0]    acc_in,
   output bcw_pkg::ctrl_type                         ctrl_out,
   output logic signed [bcw_pkg::ACC_W-1:0]          acc_out
);
   import bcw_pkg::*;

   localparam int PROD_W = ACC_W + OFFSET_W;

   coef_set_type              cs;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  rnd;
   logic signed [ACC_W-1:0]   coef_term;
   ctrl_type                  ctrl_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in_next;

   always_comb begin
      cs          = coefs(ctrl_in.order, ctrl_in.index);
      prod        = PROD_W'(acc_in) * PROD_W'(ctrl_in.x);
      rnd         = (prod + PROD_W'(64'd1 << (OFFSET_FRAC_BITS - 1))) >>> OFFSET_FRAC_BITS;
      coef_term   = ACC_W'(cs[step]) <<< ACC_FRAC_BITS;
      acc_in_next = ACC_W'(rnd) + coef_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.kind  <= ctrl_in.kind;
      ctrl_ff.order <= ctrl_in.order;
      ctrl_ff.index <= ctrl_in.index;
      ctrl_ff.x     <= ctrl_in.x;
      acc_ff        <= acc_in_next;
   end

   assign ctrl_out = ctrl_ff;
   assign acc_out  = acc_ff;
endmodule
`default_nettype wire

FILE: sv/bcw_checker.sv
`default_nettype none
module bcw_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire                          rsp_valid,
   input wire [bcw_pkg::WEIGHT_W-1:0]  rsp_weight,
   input wire                          rsp_index_error
);
   import bcw_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##10 rsp_valid)
      else $error("result word missing after accept");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_weight == '0))
      else $error("error word with nonzero weight");

   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight <= (WEIGHT_W'(1) << WEIGHT_FRAC_BITS)))
      else $error("weight above one");
endmodule

bind bspline_charge_weight_unit bcw_checker u_bcw_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_weight      (rsp_weight),
   .rsp_index_error (rsp_index_error)
);
`default_nettype wire
